### rtl/face_track_table_unit_defines.svh
// ----------------------------------------------------------------------------
// face track table unit assertion macros
// shared property forms for the result channel checker
// ----------------------------------------------------------------------------
`ifndef FACE_TRACK_TABLE_UNIT_DEFINES_SVH
`define FACE_TRACK_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define FTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ftt_pkg.sv
// ----------------------------------------------------------------------------
// ftt_pkg
// constants, codes and controller/datapath bundles for the face track table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftt_pkg;

  localparam int MAX_TRACKS    = 20;
  localparam int LINGER_FRAMES = 20;
  localparam int FRAC_BITS     = 8;

  localparam int SLOT_W  = $clog2(MAX_TRACKS);
  localparam int DEPTH   = MAX_TRACKS * 4;
  localparam int ADDR_W  = SLOT_W + 2;
  localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
  localparam int AGE_W   = 7;
  localparam int IDX_W   = 6;
  localparam int RECT_W  = 10;
  localparam int PIX_W   = 16;
  localparam int VAL_W   = 32;

  localparam int SCREEN_H  = 1080;
  localparam int FACE_MUL  = 13 << FRAC_BITS;
  localparam int CONV_W    = $clog2((1 << RECT_W) * FACE_MUL);
  localparam int RECIP_SHIFT = CONV_W + 4;
  localparam longint RECIP_MUL = ((64'd1 << RECIP_SHIFT) + 9) / 10;
  localparam int RECIP_W   = $clog2(RECIP_MUL + 1);
  localparam int PROD_W    = CONV_W + RECIP_W;

  localparam int GAIN_W    = 8;
  localparam int MUL_W     = VAL_W + GAIN_W + 1;
  localparam int ACC_W     = MUL_W + 2;
  localparam int SAT_IN_W  = ACC_W + 1;
  localparam int DIST_W    = VAL_W + 2;

  localparam int IN_DATA_W  = 4 * RECT_W;
  localparam int OUT_DATA_W = 72;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [11:0] RST_MATCH_DIST = 12'd200;
  localparam logic [4:0]  RST_HOLD       = 5'd5;
  localparam logic [7:0]  RST_POS_P      = 8'd230;
  localparam logic [7:0]  RST_POS_I      = 8'd26;
  localparam logic [7:0]  RST_POS_D      = 8'd13;
  localparam logic [7:0]  RST_SIZE_P     = 8'd51;
  localparam logic [7:0]  RST_SIZE_I     = 8'd51;
  localparam logic [7:0]  RST_SIZE_D     = 8'd26;

  localparam logic signed [AGE_W-1:0] AGE_FREE = AGE_W'(-LINGER_FRAMES);

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCH  = 3'd0,
    ST_NEW    = 3'd1,
    ST_NOFREE = 3'd2,
    ST_OVER   = 3'd3,
    ST_REPORT = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_DIST = 4'd0,
    CFG_HOLD       = 4'd1,
    CFG_POS_P      = 4'd2,
    CFG_POS_I      = 4'd3,
    CFG_POS_D      = 4'd4,
    CFG_SIZE_P     = 4'd5,
    CFG_SIZE_I     = 4'd6,
    CFG_SIZE_D     = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TGT_X, TGT_Y, TGT_W, TGT_H, TGT_ZERO
  } tgt_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        fld_idx;
    tgt_t              tgt;
    status_t           status;
    logic              size_gain;
    logic              zero_src;
    logic              load_wr;
    logic              upd_e;
    logic              upd_di;
    logic              upd_mul;
    logic              upd_acc;
    logic              upd_wr;
    logic              conv_a;
    logic              conv_b;
    logic              dx_cap;
    logic              dy_cap;
    logic              age_hold;
    logic              age_tick;
    logic              cnt_inc;
    logic              cnt_clr;
    logic              fld_cap;
    logic              out_load;
    logic              out_show;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic cnt_full;
    logic slot_live;
    logic slot_free;
    logic neg_after;
    logic hit;
    logic out_free;
  } sts_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
    logic [SAT_IN_W-VAL_W:0] hi;
    hi = x[SAT_IN_W-1:VAL_W-1];
    if ((&hi) || !(|hi)) return x[VAL_W-1:0];
    return x[SAT_IN_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

endpackage

### rtl/ftt_datapath.sv
// ----------------------------------------------------------------------------
// ftt_datapath
// filter memories, slot ages, smoothing filter unit, conversion and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftt_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ftt_pkg::cmd_t                   cmd,
  input  logic                            in_load,
  input  logic [ftt_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  logic                            cfg_valid,
  input  logic [ftt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            m_tready,
  output ftt_pkg::sts_t                   sts,
  output logic                            m_tvalid,
  output logic [ftt_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [ftt_pkg::STATUS_W-1:0]    m_tuser,
  output logic                            m_tlast
);
  import ftt_pkg::*;

  logic [11:0]       match_dist;
  logic [4:0]        hold;
  logic [GAIN_W-1:0] pos_p, pos_i, pos_d, size_p, size_i, size_d;

  logic              req_tick;
  logic [RECT_W-1:0] col, row, wid, hei;
  logic [CNT_W-1:0]  frame_cnt;

  logic signed [AGE_W-1:0] age [MAX_TRACKS];

  logic signed [VAL_W-1:0] mem_v [DEPTH];
  logic signed [VAL_W-1:0] mem_p [DEPTH];
  logic signed [VAL_W-1:0] mem_i [DEPTH];
  logic signed [VAL_W-1:0] mem_d [DEPTH];
  logic signed [VAL_W-1:0] rd_v, rd_p, rd_i;

  logic signed [VAL_W-1:0] tx, ty, tw, th, tgt_val;
  logic [CONV_W-1:0]       nw, nh;
  logic [PROD_W-1:0]       pw, ph;

  logic [VAL_W:0]          dx, dy;
  logic signed [VAL_W:0]   dsx, dsy;

  logic signed [VAL_W-1:0] ue, uv, up, ui, ud;
  logic signed [VAL_W-1:0] v_src, p_src, i_src, v_new;
  logic signed [MUL_W-1:0] mp, mi, md;
  logic signed [ACC_W-1:0] acc;
  logic signed [SAT_IN_W-1:0] e_sum, v_sum;
  logic signed [GAIN_W:0]  gp, gi, gd;
  logic                    wr_neg;

  logic [PIX_W-1:0]        fld [4];
  logic signed [AGE_W-1:0] age_s, age_t;
  logic                    live_s;

  function automatic logic [PIX_W-1:0] pix(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] t;
    t = v[VAL_W-1] ? ((v + VAL_W'(signed'((1 << FRAC_BITS) - 1))) >>> FRAC_BITS)
                   : (v >>> FRAC_BITS);
    if (t > VAL_W'(signed'(32767)))  return {1'b0, {(PIX_W-1){1'b1}}};
    if (t < VAL_W'(signed'(-32768))) return {1'b1, {(PIX_W-1){1'b0}}};
    return t[PIX_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_dist <= RST_MATCH_DIST;
      hold       <= RST_HOLD;
      pos_p      <= RST_POS_P;
      pos_i      <= RST_POS_I;
      pos_d      <= RST_POS_D;
      size_p     <= RST_SIZE_P;
      size_i     <= RST_SIZE_I;
      size_d     <= RST_SIZE_D;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MATCH_DIST: match_dist <= cfg_data;
        CFG_HOLD:       hold       <= cfg_data[4:0];
        CFG_POS_P:      pos_p      <= cfg_data[GAIN_W-1:0];
        CFG_POS_I:      pos_i      <= cfg_data[GAIN_W-1:0];
        CFG_POS_D:      pos_d      <= cfg_data[GAIN_W-1:0];
        CFG_SIZE_P:     size_p     <= cfg_data[GAIN_W-1:0];
        CFG_SIZE_I:     size_i     <= cfg_data[GAIN_W-1:0];
        CFG_SIZE_D:     size_d     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and target conversion
  assign pw = PROD_W'(nw) * PROD_W'(RECIP_MUL);
  assign ph = PROD_W'(nh) * PROD_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (in_load) begin
      req_tick <= s_tuser;
      col      <= s_tdata[RECT_W-1:0];
      row      <= s_tdata[2*RECT_W-1:RECT_W];
      wid      <= s_tdata[3*RECT_W-1:2*RECT_W];
      hei      <= s_tdata[4*RECT_W-1:3*RECT_W];
    end
    if (cmd.conv_a) begin
      tx <= VAL_W'(({2'b0, row} << 1) + {2'b0, hei}) << FRAC_BITS;
      ty <= VAL_W'(signed'(13'(SCREEN_H) - ({3'b0, col} << 1) - {3'b0, wid})) <<< FRAC_BITS;
      nw <= CONV_W'(hei) * CONV_W'(FACE_MUL);
      nh <= CONV_W'(wid) * CONV_W'(FACE_MUL);
    end
    if (cmd.conv_b) begin
      tw <= VAL_W'(pw[PROD_W-1:RECIP_SHIFT]);
      th <= VAL_W'(ph[PROD_W-1:RECIP_SHIFT]);
    end
  end

  always_comb begin
    unique case (cmd.tgt)
      TGT_X:   tgt_val = tx;
      TGT_Y:   tgt_val = ty;
      TGT_W:   tgt_val = tw;
      TGT_H:   tgt_val = th;
      default: tgt_val = '0;
    endcase
  end

  // match distance
  assign dsx = (VAL_W+1)'(tx) - (VAL_W+1)'(rd_v);
  assign dsy = (VAL_W+1)'(ty) - (VAL_W+1)'(rd_v);

  always_ff @(posedge clk) begin
    if (cmd.dx_cap) dx <= dsx[VAL_W] ? -dsx : dsx;
    if (cmd.dy_cap) dy <= dsy[VAL_W] ? -dsy : dsy;
  end

  // smoothing filter unit
  assign v_src = cmd.zero_src ? '0 : rd_v;
  assign p_src = cmd.zero_src ? '0 : rd_p;
  assign i_src = cmd.zero_src ? '0 : rd_i;
  assign e_sum = SAT_IN_W'(tgt_val) - SAT_IN_W'(v_src);
  assign gp    = {1'b0, cmd.size_gain ? size_p : pos_p};
  assign gi    = {1'b0, cmd.size_gain ? size_i : pos_i};
  assign gd    = {1'b0, cmd.size_gain ? size_d : pos_d};
  assign v_sum = SAT_IN_W'(uv) + SAT_IN_W'(acc >>> FRAC_BITS);
  assign v_new = sat32(v_sum);
  assign wr_neg = v_new[VAL_W-1];

  always_ff @(posedge clk) begin
    if (cmd.upd_e) begin
      ue <= sat32(e_sum);
      uv <= v_src;
      up <= p_src;
      ui <= i_src;
    end
    if (cmd.upd_di) begin
      ud <= sat32(SAT_IN_W'(ue) - SAT_IN_W'(up));
      ui <= sat32(SAT_IN_W'(ui) + SAT_IN_W'(ue));
    end
    if (cmd.upd_mul) begin
      mp <= ue * gp;
      mi <= ui * gi;
      md <= ud * gd;
    end
    if (cmd.upd_acc) acc <= ACC_W'(mp) + ACC_W'(mi) + ACC_W'(md);
  end

  // filter state memories
  always_ff @(posedge clk) begin
    rd_v <= mem_v[cmd.addr];
    rd_p <= mem_p[cmd.addr];
    rd_i <= mem_i[cmd.addr];
    if (cmd.load_wr) begin
      mem_v[cmd.addr] <= tgt_val;
      mem_p[cmd.addr] <= '0;
      mem_i[cmd.addr] <= '0;
      mem_d[cmd.addr] <= '0;
    end else if (cmd.upd_wr) begin
      mem_v[cmd.addr] <= wr_neg ? '0 : v_new;
      mem_p[cmd.addr] <= wr_neg ? '0 : ue;
      mem_i[cmd.addr] <= wr_neg ? '0 : ui;
      mem_d[cmd.addr] <= wr_neg ? '0 : ud;
    end
  end

  // slot ages and frame count
  assign age_s  = age[cmd.slot];
  assign live_s = age_s > AGE_FREE;
  assign age_t  = live_s ? age_s - AGE_W'(1) : age_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TRACKS; k++) age[k] <= AGE_FREE;
      frame_cnt <= '0;
    end else begin
      if (cmd.age_tick) age[cmd.slot] <= age_t;
      else if (cmd.age_hold) age[cmd.slot] <= AGE_W'(hold);
      if (cmd.cnt_clr) frame_cnt <= '0;
      else if (cmd.cnt_inc) frame_cnt <= frame_cnt + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fld_cap) fld[cmd.fld_idx] <= pix(rd_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= cmd.status;
      m_tlast <= cmd.out_last;
      if (cmd.out_show) begin
        m_tdata <= {1'b0, fld[3], fld[2], fld[1], fld[0], live_s, IDX_W'(cmd.slot)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  assign sts.is_tick   = req_tick;
  assign sts.cnt_full  = frame_cnt >= CNT_W'(MAX_TRACKS);
  assign sts.slot_live = live_s;
  assign sts.slot_free = age_s == AGE_FREE;
  assign sts.neg_after = age_t < 0;
  assign sts.hit       = (DIST_W'(dx) + DIST_W'(dy)) < DIST_W'({match_dist, {FRAC_BITS{1'b0}}});
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

### rtl/ftt_ctrl.sv
// ----------------------------------------------------------------------------
// ftt_ctrl
// sequencer for slot scans, filter updates, ticks and result readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          in_load,
  input  ftt_pkg::sts_t sts,
  output ftt_pkg::cmd_t cmd
);
  import ftt_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_CONV_B,
    S_SCAN_X, S_SCAN_Y, S_SCAN_D, S_SCAN_CMP,
    S_FREE, S_NEW_X, S_NEW_Y,
    S_U_RD, S_U_E, S_U_DI, S_U_MUL, S_U_ACC, S_U_WR,
    S_HOLD, S_READ, S_EMIT, S_TICK_AGE, S_TICK_NEXT, S_DROP
  } state_t;

  typedef enum logic [1:0] {CTX_MATCH, CTX_NEW, CTX_TICK} ctx_t;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TRACKS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  state_t            state;
  ctx_t              ctx;
  status_t           stat;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        j;
  logic [2:0]        rcnt;
  logic [ADDR_W-1:0] clr_cnt;
  tgt_t              tgt_j;

  assign s_tready = state == S_IDLE;
  assign in_load  = s_tvalid && s_tready;

  always_comb begin
    unique case (j)
      2'd0:    tgt_j = TGT_X;
      2'd1:    tgt_j = TGT_Y;
      2'd2:    tgt_j = TGT_W;
      default: tgt_j = TGT_H;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.tgt       = TGT_ZERO;
    cmd.status    = stat;
    cmd.slot      = slot;
    cmd.addr      = {slot, j};
    cmd.size_gain = j[1];
    unique case (state)
      S_CLEAR: begin
        cmd.addr    = clr_cnt;
        cmd.load_wr = 1'b1;
      end
      S_DISPATCH: begin
        cmd.conv_a  = !sts.is_tick && !sts.cnt_full;
        cmd.cnt_inc = !sts.is_tick && !sts.cnt_full;
      end
      S_CONV_B:  cmd.conv_b = 1'b1;
      S_SCAN_X:  cmd.addr = {slot, 2'd0};
      S_SCAN_Y: begin
        cmd.addr   = {slot, 2'd1};
        cmd.dx_cap = 1'b1;
      end
      S_SCAN_D:  cmd.dy_cap = 1'b1;
      S_NEW_X: begin
        cmd.addr    = {slot, 2'd0};
        cmd.tgt     = TGT_X;
        cmd.load_wr = 1'b1;
      end
      S_NEW_Y: begin
        cmd.addr    = {slot, 2'd1};
        cmd.tgt     = TGT_Y;
        cmd.load_wr = 1'b1;
      end
      S_U_E: begin
        cmd.tgt      = (ctx == CTX_TICK) ? TGT_ZERO : tgt_j;
        cmd.zero_src = ctx == CTX_NEW;
        cmd.upd_e    = 1'b1;
      end
      S_U_DI:  cmd.upd_di  = 1'b1;
      S_U_MUL: cmd.upd_mul = 1'b1;
      S_U_ACC: cmd.upd_acc = 1'b1;
      S_U_WR:  cmd.upd_wr  = 1'b1;
      S_HOLD:  cmd.age_hold = 1'b1;
      S_READ: begin
        cmd.addr    = {slot, rcnt[1:0]};
        cmd.fld_cap = rcnt != 3'd0;
        cmd.fld_idx = 2'(rcnt - 3'd1);
      end
      S_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.out_show = 1'b1;
        cmd.out_last = (stat != ST_REPORT) || (slot == SLOT_LAST);
      end
      S_TICK_AGE:  cmd.age_tick = 1'b1;
      S_TICK_NEXT: cmd.cnt_clr = slot == SLOT_LAST;
      S_DROP: begin
        cmd.out_load = sts.out_free;
        cmd.out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ctx     <= CTX_MATCH;
      stat    <= ST_MATCH;
      slot    <= '0;
      j       <= '0;
      rcnt    <= '0;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          slot <= '0;
          priority if (sts.is_tick) begin
            state <= S_TICK_AGE;
          end else if (sts.cnt_full) begin
            stat  <= ST_OVER;
            state <= S_DROP;
          end else begin
            state <= S_CONV_B;
          end
        end
        S_CONV_B:  state <= S_SCAN_X;
        S_SCAN_X:  state <= S_SCAN_Y;
        S_SCAN_Y:  state <= S_SCAN_D;
        S_SCAN_D:  state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          priority if (sts.hit && sts.slot_live) begin
            ctx   <= CTX_MATCH;
            j     <= 2'd0;
            state <= S_U_RD;
          end else if (slot == SLOT_LAST) begin
            slot  <= '0;
            state <= S_FREE;
          end else begin
            slot  <= slot + SLOT_W'(1);
            state <= S_SCAN_X;
          end
        end
        S_FREE: begin
          priority if (sts.slot_free) begin
            state <= S_NEW_X;
          end else if (slot == SLOT_LAST) begin
            stat  <= ST_NOFREE;
            state <= S_DROP;
          end else begin
            slot <= slot + SLOT_W'(1);
          end
        end
        S_NEW_X: state <= S_NEW_Y;
        S_NEW_Y: begin
          ctx   <= CTX_NEW;
          j     <= 2'd2;
          state <= S_U_RD;
        end
        S_U_RD:  state <= S_U_E;
        S_U_E:   state <= S_U_DI;
        S_U_DI:  state <= S_U_MUL;
        S_U_MUL: state <= S_U_ACC;
        S_U_ACC: state <= S_U_WR;
        S_U_WR: begin
          if (j == 2'd3) begin
            unique case (ctx)
              CTX_MATCH: begin
                stat  <= ST_MATCH;
                state <= S_HOLD;
              end
              CTX_NEW: begin
                stat  <= ST_NEW;
                state <= S_HOLD;
              end
              default: state <= S_TICK_NEXT;
            endcase
          end else begin
            j     <= j + 2'd1;
            state <= S_U_RD;
          end
        end
        S_HOLD: begin
          rcnt  <= '0;
          state <= S_READ;
        end
        S_READ: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd4) state <= S_EMIT;
        end
        S_EMIT: begin
          if (sts.out_free) begin
            if ((stat == ST_REPORT) && (slot != SLOT_LAST)) begin
              slot  <= slot + SLOT_W'(1);
              rcnt  <= '0;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TICK_AGE: begin
          if (sts.neg_after) begin
            ctx   <= CTX_TICK;
            j     <= 2'd2;
            state <= S_U_RD;
          end else begin
            state <= S_TICK_NEXT;
          end
        end
        S_TICK_NEXT: begin
          if (slot == SLOT_LAST) begin
            slot  <= '0;
            stat  <= ST_REPORT;
            rcnt  <= '0;
            state <= S_READ;
          end else begin
            slot  <= slot + SLOT_W'(1);
            state <= S_TICK_AGE;
          end
        end
        S_DROP: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/face_track_table_unit.sv
// ----------------------------------------------------------------------------
// face_track_table_unit
// tracked face box table with per-slot smoothing filters, top level
//
//   channel | direction | handshake          | carries
//   s       | in        | s_tvalid/s_tready  | detection or frame tick request
//   m       | out       | m_tvalid/m_tready  | match, new, drop or slot report
//   cfg     | in        | cfg_valid/cfg_ready| register index and write data
//
// one request at a time; a detection scans the slots for a match, makes up to one
// pass over the free flags, runs four filter updates on a match or two on a new
// slot, sets the age and reads out, each update six steps of the shared filter unit
// a tick ages every slot, updating the size filters where the age goes negative,
// then reports every slot; reset is followed by a pass clearing the filter memories
// a stalled result holds the sequencer only when it has the next result ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module face_track_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ftt_pkg::IN_DATA_W-1:0]   s_tdata,   // rect_col, rect_row, rect_width, rect_height
  input  logic                            s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ftt_pkg::OUT_DATA_W-1:0]  m_tdata,   // slot_index, slot_live, centre_x, centre_y,
                                                     // half_width, half_height, zero pad
  output logic [ftt_pkg::STATUS_W-1:0]    m_tuser,   // status
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ftt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_load;

  assign cfg_ready = 1'b1;

  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_load  (in_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_load   (in_load),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### rtl/ftt_checker.sv
// ----------------------------------------------------------------------------
// ftt_checker
// result channel checks on the top level ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "face_track_table_unit_defines.svh"

module ftt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ftt_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [ftt_pkg::STATUS_W-1:0]    m_tuser,
  input logic                            m_tlast
);
  import ftt_pkg::*;

  `FTT_ASSERT_NEXT(a_held, m_tvalid && !m_tready, m_tvalid, "result withdrawn while stalled")
  `FTT_ASSERT_NEXT(a_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `FTT_ASSERT_SAME(a_single_last, m_tvalid && (m_tuser == ST_MATCH || m_tuser == ST_NEW || m_tuser == ST_NOFREE || m_tuser == ST_OVER), m_tlast, "detection result without last")
  `FTT_ASSERT_SAME(a_drop_empty, m_tvalid && (m_tuser == ST_NOFREE || m_tuser == ST_OVER), m_tdata == '0, "dropped detection carries box data")

endmodule

bind face_track_table_unit ftt_checker u_ftt_checker (.*);

### sim/face_track_table_unit_test.sv
// ----------------------------------------------------------------------------
// face_track_table_unit_test
// drives detection and frame tick requests into the face track table with
// random gaps and output stalls, keeps its own model of the slot table and
// filters, and compares every result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module face_track_table_unit_test;
  import ftt_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        live;
    logic [15:0] cx, cy, hw, hh;
    logic        last;
  } track_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  face_track_table_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  int fv[DEPTH], fp[DEPTH], fi[DEPTH], fd[DEPTH];
  int age[MAX_TRACKS];
  int det_count;
  int md, hold, pgp, pgi, pgd, sgp, sgi, sgd;

  track_res_t box_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  int face_col[4], face_row[4], face_w[4], face_h[4];

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic void filter_load(int k, int v);
    fv[k] = v; fp[k] = 0; fi[k] = 0; fd[k] = 0;
  endfunction

  function automatic void smooth(int k, longint tgt, int gp, int gi, int gd);
    int e;
    longint acc;
    e = clamp32(tgt - longint'(fv[k]));
    fd[k] = clamp32(longint'(e) - longint'(fp[k]));
    fi[k] = clamp32(longint'(fi[k]) + longint'(e));
    fp[k] = e;
    acc = longint'(fp[k]) * gp + longint'(fi[k]) * gi + longint'(fd[k]) * gd;
    fv[k] = clamp32(longint'(fv[k]) + (acc >>> 8));
    if (fv[k] < 0) filter_load(k, 0);
  endfunction

  function automatic logic [15:0] to_pix(int v);
    int t;
    t = v / (1 << FRAC_BITS);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic void push_box(status_t st, int s, bit show, bit last);
    track_res_t r;
    r = '{st, 6'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, last};
    if (show) begin
      r.slot = 6'(s);
      r.live = age[s] > -LINGER_FRAMES;
      r.cx = to_pix(fv[s*4]);
      r.cy = to_pix(fv[s*4+1]);
      r.hw = to_pix(fv[s*4+2]);
      r.hh = to_pix(fv[s*4+3]);
    end
    box_q.insert(box_q.size(), r);
  endfunction

  function automatic void track_step(bit tick, int col, int row, int wid, int hei);
    longint one, tx, ty, tw, th, lim, dx, dy;
    one = 1 << FRAC_BITS;
    if (tick) begin
      for (int s = 0; s < MAX_TRACKS; s++) begin
        if (age[s] > -LINGER_FRAMES) age[s]--;
        if (age[s] < 0) begin
          smooth(s*4+2, 0, sgp, sgi, sgd);
          smooth(s*4+3, 0, sgp, sgi, sgd);
        end
      end
      for (int s = 0; s < MAX_TRACKS; s++) push_box(ST_REPORT, s, 1, s == MAX_TRACKS - 1);
      det_count = 0;
      return;
    end
    if (det_count >= MAX_TRACKS) begin
      push_box(ST_OVER, 0, 0, 1);
      return;
    end
    det_count++;
    tw = longint'(hei) * 13 * one / 10;
    th = longint'(wid) * 13 * one / 10;
    tx = longint'(2 * row + hei) * one;
    ty = longint'(SCREEN_H - 2 * col - wid) * one;
    lim = longint'(md) * one;
    for (int s = 0; s < MAX_TRACKS; s++) begin
      dx = tx - fv[s*4];
      dy = ty - fv[s*4+1];
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx + dy < lim && age[s] > -LINGER_FRAMES) begin
        smooth(s*4, tx, pgp, pgi, pgd);
        smooth(s*4+1, ty, pgp, pgi, pgd);
        smooth(s*4+2, tw, sgp, sgi, sgd);
        smooth(s*4+3, th, sgp, sgi, sgd);
        age[s] = hold;
        push_box(ST_MATCH, s, 1, 1);
        return;
      end
    end
    for (int s = 0; s < MAX_TRACKS; s++) begin
      if (age[s] == -LINGER_FRAMES) begin
        filter_load(s*4, int'(tx));
        filter_load(s*4+1, int'(ty));
        filter_load(s*4+2, 0);
        filter_load(s*4+3, 0);
        smooth(s*4+2, tw, sgp, sgi, sgd);
        smooth(s*4+3, th, sgp, sgi, sgd);
        age[s] = hold;
        push_box(ST_NEW, s, 1, 1);
        return;
      end
    end
    push_box(ST_NOFREE, 0, 0, 1);
  endfunction

  // result stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    track_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (box_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual status %0d", $time, m_tuser);
      end else begin
        e = box_q.pop_front();
        check_field("status", e.status, m_tuser);
        check_field("slot_index", e.slot, m_tdata[5:0]);
        check_field("slot_live", e.live, m_tdata[6]);
        check_field("centre_x", e.cx, m_tdata[22:7]);
        check_field("centre_y", e.cy, m_tdata[38:23]);
        check_field("half_width", e.hw, m_tdata[54:39]);
        check_field("half_height", e.hh, m_tdata[70:55]);
        check_field("last", e.last, m_tlast);
      end
    end
  end

  task automatic send_req(bit tick, int col, int row, int wid, int hei);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tuser = tick;
    s_tdata = {10'(hei), 10'(wid), 10'(row), 10'(col)};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    track_step(tick, col, row, wid, hei);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_rand_det();
    send_req(0, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
    wait (box_q.size() == 0);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = 12'(data);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MATCH_DIST: md = data & 12'hfff;
      CFG_HOLD:       hold = data & 31;
      CFG_POS_P:      pgp = data & 255;
      CFG_POS_I:      pgi = data & 255;
      CFG_POS_D:      pgd = data & 255;
      CFG_SIZE_P:     sgp = data & 255;
      CFG_SIZE_I:     sgi = data & 255;
      CFG_SIZE_D:     sgd = data & 255;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic cfg_all(int m, int h, int p_p, int p_i, int p_d, int z_p, int z_i, int z_d);
    cfg_write(CFG_MATCH_DIST, m);
    cfg_write(CFG_HOLD, h);
    cfg_write(CFG_POS_P, p_p);
    cfg_write(CFG_POS_I, p_i);
    cfg_write(CFG_POS_D, p_d);
    cfg_write(CFG_SIZE_P, z_p);
    cfg_write(CFG_SIZE_I, z_i);
    cfg_write(CFG_SIZE_D, z_d);
  endtask

  // table fill, frame limit, no free slot, then a match
  task automatic test_table_limits();
    cfg_write(CFG_MATCH_DIST, 0);
    send_req(0, 0, 0, 0, 0);
    send_req(0, 1023, 1023, 1023, 1023);
    send_req(0, 1023, 0, 0, 1023);
    send_req(0, 0, 1023, 1023, 0);
    for (int i = 4; i < MAX_TRACKS; i++) send_rand_det();
    send_req(0, 100, 100, 50, 50);
    send_req(1, 0, 0, 0, 0);
    send_req(0, 200, 300, 60, 80);
    cfg_write(CFG_MATCH_DIST, 4095);
    send_req(0, 0, 0, 0, 0);
  endtask

  task automatic test_registers();
    for (int k = 1; k <= 8; k++) cfg_write(4'(CFG_SIZE_D) + 4'(k), $urandom_range(0, 4095));
    cfg_all($urandom_range(0, 4095), $urandom_range(0, 31), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic run_frames(int n_items);
    int sent, n, f;
    sent = 0;
    while (sent < n_items) begin
      n = ($urandom_range(0, 9) == 0) ? MAX_TRACKS + 2 : $urandom_range(0, 6);
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_rand_det();
        end else begin
          f = $urandom_range(0, 3);
          send_req(0, face_col[f] + $urandom_range(0, 8), face_row[f] + $urandom_range(0, 8),
                   face_w[f] + $urandom_range(0, 8), face_h[f] + $urandom_range(0, 8));
        end
      end
      send_req(1, 0, 0, 0, 0);
      sent += n + 1;
      for (int k = 0; k < 4; k++) begin
        face_col[k] = (face_col[k] + $urandom_range(0, 10)) % 1000;
        face_row[k] = (face_row[k] + $urandom_range(0, 10)) % 1000;
      end
    end
  endtask

  task automatic test_random();
    for (int k = 0; k < 4; k++) begin
      face_col[k] = $urandom_range(0, 1000);
      face_row[k] = $urandom_range(0, 1000);
      face_w[k] = $urandom_range(0, 1015);
      face_h[k] = $urandom_range(0, 1015);
    end
    run_frames(50);
    cfg_all(4095, 31, 255, 255, 255, 255, 255, 255);
    run_frames(50);
    cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
    run_frames(40);
    cfg_all(200 + $urandom_range(0, 300), $urandom_range(0, 31), 230, 26, 13, 51, 51, 26);
    run_frames(20);
    quiet = 1'b1;
    run_frames(30);
  endtask

  initial begin
    md = RST_MATCH_DIST; hold = RST_HOLD;
    pgp = RST_POS_P; pgi = RST_POS_I; pgd = RST_POS_D;
    sgp = RST_SIZE_P; sgi = RST_SIZE_I; sgd = RST_SIZE_D;
    for (int k = 0; k < DEPTH; k++) filter_load(k, 0);
    for (int s = 0; s < MAX_TRACKS; s++) age[s] = -LINGER_FRAMES;
    det_count = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_table_limits();
    test_registers();
    test_random();
    wait (box_q.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ftt_pkg.sv
rtl/ftt_datapath.sv
rtl/ftt_ctrl.sv
rtl/face_track_table_unit.sv
rtl/ftt_checker.sv
sim/face_track_table_unit_test.sv
